### sv/ntc_pkg.sv
// shared types, widths, constants and curve table for the ntc temperature block
`timescale 1ns / 1ps

package ntc_pkg;

  localparam int unsigned ROM_ENTRIES = 191;
  localparam int unsigned ADDR_W      = 8;
  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned CAL_W       = 11;
  localparam int unsigned TEMP_W      = 16;
  localparam int unsigned CURVE_W     = 12;
  localparam int unsigned VAL_W       = 13;
  localparam int unsigned DIVD_W      = 17;
  localparam int unsigned QUOT_W      = 4;

  localparam logic [VAL_W-1:0]         FULL_SCALE = 13'd4096;
  // index offset of 39 entries times ten, plus the trim of 15 tenths
  localparam logic signed [TEMP_W:0]   INDEX_BIAS = 17'sd405;
  localparam logic [TEMP_W-1:0]        OOR_CODE   = 16'h7fff;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CURVE_W-1:0] curve_t;

  localparam curve_t CURVE [0:ROM_ENTRIES-1] = '{
    12'd193,  12'd204,  12'd215,  12'd227,  12'd239,  12'd252,  12'd265,  12'd279,
    12'd294,  12'd309,  12'd324,  12'd340,  12'd357,  12'd375,  12'd393,  12'd411,
    12'd431,  12'd451,  12'd471,  12'd492,  12'd514,  12'd537,  12'd560,  12'd584,
    12'd609,  12'd635,  12'd661,  12'd687,  12'd715,  12'd743,  12'd772,  12'd801,
    12'd831,  12'd862,  12'd893,  12'd925,  12'd957,  12'd991,  12'd1024, 12'd1058,
    12'd1093, 12'd1128, 12'd1164, 12'd1200, 12'd1236, 12'd1273, 12'd1310, 12'd1348,
    12'd1386, 12'd1424, 12'd1463, 12'd1501, 12'd1540, 12'd1579, 12'd1618, 12'd1657,
    12'd1697, 12'd1736, 12'd1775, 12'd1815, 12'd1854, 12'd1893, 12'd1932, 12'd1971,
    12'd2010, 12'd2048, 12'd2087, 12'd2125, 12'd2163, 12'd2200, 12'd2238, 12'd2274,
    12'd2311, 12'd2347, 12'd2383, 12'd2418, 12'd2453, 12'd2488, 12'd2522, 12'd2556,
    12'd2589, 12'd2622, 12'd2654, 12'd2685, 12'd2717, 12'd2747, 12'd2777, 12'd2807,
    12'd2836, 12'd2865, 12'd2893, 12'd2921, 12'd2948, 12'd2974, 12'd3000, 12'd3026,
    12'd3051, 12'd3075, 12'd3099, 12'd3123, 12'd3146, 12'd3168, 12'd3190, 12'd3212,
    12'd3233, 12'd3253, 12'd3273, 12'd3293, 12'd3312, 12'd3331, 12'd3349, 12'd3367,
    12'd3384, 12'd3401, 12'd3418, 12'd3434, 12'd3450, 12'd3465, 12'd3481, 12'd3495,
    12'd3510, 12'd3524, 12'd3537, 12'd3551, 12'd3564, 12'd3576, 12'd3588, 12'd3600,
    12'd3612, 12'd3624, 12'd3635, 12'd3646, 12'd3656, 12'd3667, 12'd3677, 12'd3686,
    12'd3696, 12'd3705, 12'd3714, 12'd3723, 12'd3732, 12'd3740, 12'd3748, 12'd3756,
    12'd3764, 12'd3772, 12'd3779, 12'd3786, 12'd3793, 12'd3800, 12'd3807, 12'd3813,
    12'd3820, 12'd3826, 12'd3832, 12'd3838, 12'd3844, 12'd3849, 12'd3855, 12'd3860,
    12'd3865, 12'd3870, 12'd3875, 12'd3880, 12'd3884, 12'd3889, 12'd3893, 12'd3898,
    12'd3902, 12'd3906, 12'd3910, 12'd3914, 12'd3918, 12'd3922, 12'd3925, 12'd3929,
    12'd3932, 12'd3936, 12'd3939, 12'd3942, 12'd3945, 12'd3949, 12'd3952, 12'd3954,
    12'd3957, 12'd3960, 12'd3963, 12'd3966, 12'd3968, 12'd3971, 12'd3973
  };

  function automatic curve_t curve_at(input addr_t idx);
    curve_t val;
    if (int'(idx) < ROM_ENTRIES) begin
      val = CURVE[idx];
    end else begin
      val = CURVE[ROM_ENTRIES-1];
    end
    return val;
  endfunction

endpackage

### sv/ntc_curve_rom.sv
// curve rom with a registered read port
`timescale 1ns / 1ps

module ntc_curve_rom
  import ntc_pkg::*;
(
  input  logic   clk,
  input  addr_t  rd_addr,
  output curve_t rd_data
);

  curve_t rd_data_r;

  always_ff @(posedge clk) begin
    rd_data_r <= curve_at(rd_addr);
  end

  assign rd_data = rd_data_r;

endmodule

### sv/ntc_serial_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ntc_serial_div
  import ntc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  curve_t            divisor,
  output logic              done,
  output logic [QUOT_W-1:0] quotient
);

  localparam int unsigned DSH_W = CURVE_W + QUOT_W - 1;
  localparam int unsigned CNT_W = $clog2(QUOT_W);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVD_W-1:0] rem_r, rem_nxt;
  logic [DSH_W-1:0]  dsh_r, dsh_nxt;
  logic [QUOT_W-1:0] q_r, q_nxt;
  logic              zero_r, zero_nxt;
  logic [DIVD_W-1:0] trial;
  logic              fits;

  assign trial = DIVD_W'(dsh_r);
  assign fits  = (rem_r >= trial);

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    zero_nxt = zero_r;
    if (start) begin
      run_nxt  = 1'b1;
      cnt_nxt  = CNT_W'(QUOT_W - 1);
      rem_nxt  = dividend;
      dsh_nxt  = {divisor, {(QUOT_W-1){1'b0}}};
      q_nxt    = '0;
      zero_nxt = (divisor == '0);
    end else if (run_r) begin
      if (fits) begin
        rem_nxt = rem_r - trial;
      end
      q_nxt   = {q_r[QUOT_W-2:0], fits};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    q_r    <= q_nxt;
    zero_r <= zero_nxt;
  end

  assign done     = done_r;
  // a zero step gives a zero fraction
  assign quotient = zero_r ? '0 : q_r;

endmodule

### sv/ntc_adc_to_temperature_top.sv
// thermistor sample to temperature: curve search, interpolation and result
`timescale 1ns / 1ps
// a sample outside the curve goes from idle straight to the registered result;
//   otherwise each search step reads the rom (S_RD) and compares (S_CMP), over
//   ceil(log2(entries+1)) steps, 8 for 191, then the curve reads (S_FLO, S_FHI,
//   S_DGO), the serial divide and the registered output; one sample at a time:
// busy stays high until the result strobe; the rom read port and the divider set the pace
// reset (rst_n low, synchronous) returns to idle and drops out_valid

module ntc_adc_to_temperature_top
  import ntc_pkg::*;
#(
  parameter int CURVE_ENTRIES = 191
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [SAMPLE_W-1:0]      in_adc_sample,
  input  logic signed [CAL_W-1:0]  in_calibration_tenths,
  output logic                     out_valid,
  output logic signed [TEMP_W-1:0] out_temperature_tenths,
  output logic                     out_out_of_range
);

  localparam int USED = (CURVE_ENTRIES > int'(ROM_ENTRIES)) ? int'(ROM_ENTRIES) :
                        ((CURVE_ENTRIES < 2) ? 2 : CURVE_ENTRIES);
  localparam curve_t FIRST_ENTRY = curve_at('0);
  localparam curve_t LAST_ENTRY  = curve_at(ADDR_W'(USED - 1));

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_FLO   = 3'd3;
  localparam logic [2:0] S_FHI   = 3'd4;
  localparam logic [2:0] S_DGO   = 3'd5;
  localparam logic [2:0] S_DWAIT = 3'd6;

  logic [2:0]               state_r, state_nxt;
  logic [VAL_W-1:0]         v_r, v_nxt;
  logic signed [CAL_W-1:0]  cal_r, cal_nxt;
  addr_t                    lo_r, lo_nxt;
  addr_t                    hi_r, hi_nxt;
  curve_t                   clo_r, clo_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [TEMP_W-1:0]        temp_r, temp_nxt;
  logic                     oor_r, oor_nxt;

  logic [VAL_W-1:0]         v_in;
  logic                     in_oor;
  addr_t                    mid;
  addr_t                    rd_addr;
  curve_t                   rd_data;
  logic                     div_start;
  logic                     div_done;
  logic [QUOT_W-1:0]        quot;
  logic [VAL_W-1:0]         offset;
  logic [DIVD_W-1:0]        dividend;
  curve_t                   divisor;
  logic [CURVE_W-1:0]       idx_x10;
  logic signed [TEMP_W:0]   temp_sum;

  ntc_curve_rom u_rom (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ntc_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quot)
  );

  assign v_in   = FULL_SCALE - VAL_W'(in_adc_sample);
  assign in_oor = (v_in <= VAL_W'(FIRST_ENTRY)) || (v_in > VAL_W'(LAST_ENTRY));
  assign mid    = lo_r + ((hi_r - lo_r) >> 1);

  always_comb begin
    unique case (state_r)
      S_FLO:   rd_addr = lo_r - 1'b1;
      S_FHI:   rd_addr = lo_r;
      default: rd_addr = mid;
    endcase
  end

  // rd_data holds the upper entry in S_DGO
  assign offset    = v_r - VAL_W'(clo_r);
  assign dividend  = DIVD_W'({offset, 3'b000}) + DIVD_W'({offset, 1'b0});
  assign divisor   = rd_data - clo_r;
  assign div_start = (state_r == S_DGO);

  assign idx_x10  = CURVE_W'({lo_r, 3'b000}) + CURVE_W'({lo_r, 1'b0});
  assign temp_sum = $signed({{(TEMP_W+1-CURVE_W){1'b0}}, idx_x10}) - INDEX_BIAS
                  + $signed({{(TEMP_W+1-QUOT_W){1'b0}}, quot})
                  + (TEMP_W+1)'(cal_r);

  always_comb begin
    state_nxt     = state_r;
    v_nxt         = v_r;
    cal_nxt       = cal_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    clo_nxt       = clo_r;
    out_valid_nxt = 1'b0;
    temp_nxt      = temp_r;
    oor_nxt       = oor_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          v_nxt   = v_in;
          cal_nxt = in_calibration_tenths;
          lo_nxt  = '0;
          hi_nxt  = ADDR_W'(USED);
          if (in_oor) begin
            out_valid_nxt = 1'b1;
            temp_nxt      = OOR_CODE;
            oor_nxt       = 1'b1;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (VAL_W'(rd_data) < v_r) begin
          lo_nxt = mid + 1'b1;
        end else begin
          hi_nxt = mid;
        end
        state_nxt = (lo_nxt < hi_nxt) ? S_RD : S_FLO;
      end
      S_FLO: begin
        state_nxt = S_FHI;
      end
      S_FHI: begin
        clo_nxt   = rd_data;
        state_nxt = S_DGO;
      end
      S_DGO: begin
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          out_valid_nxt = 1'b1;
          temp_nxt      = temp_sum[TEMP_W-1:0];
          oor_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    cal_r  <= cal_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    clo_r  <= clo_nxt;
    temp_r <= temp_nxt;
    oor_r  <= oor_nxt;
  end

  assign busy                   = (state_r != S_IDLE);
  assign out_valid              = out_valid_r;
  assign out_temperature_tenths = $signed(temp_r);
  assign out_out_of_range       = oor_r;

endmodule

### test/tb_ntc_adc_to_temperature_top.sv
// testbench for the ntc sample to temperature block: random and directed samples, checked results
`timescale 1ns / 1ps

module tb_ntc_adc_to_temperature_top;
  import ntc_pkg::*;

  localparam int CURVE_N          = 191;
  localparam int USED_N           = (CURVE_N > ROM_ENTRIES) ? ROM_ENTRIES :
                                    ((CURVE_N < 2) ? 2 : CURVE_N);
  localparam int INDEX_OFFSET     = 39;
  localparam int TRIM_TENTHS      = 15;
  localparam int TENTHS_PER_STEP  = 10;
  localparam int SETTLE_CYCLES    = 40;
  localparam int ITEMS_PER_PHASE  = 213;
  localparam longint CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [SAMPLE_W-1:0]      adc;
    logic signed [CAL_W-1:0]  cal;
  } sample_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     oor;
  } reading_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [SAMPLE_W-1:0]      in_adc_sample = '0;
  logic signed [CAL_W-1:0]  in_calibration_tenths = '0;
  logic                     out_valid;
  logic signed [TEMP_W-1:0] out_temperature_tenths;
  logic                     out_out_of_range;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  sample_t  sample_on_bus;
  int       sender_idle_pct = 0;
  int       failures = 0;
  longint   cycle_count = 0;

  ntc_adc_to_temperature_top #(
    .CURVE_ENTRIES(CURVE_N)
  ) i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_adc_sample         (in_adc_sample),
    .in_calibration_tenths (in_calibration_tenths),
    .out_valid             (out_valid),
    .out_temperature_tenths(out_temperature_tenths),
    .out_out_of_range      (out_out_of_range)
  );

  always #10 clk = ~clk;

  // inverted sample, curve search by linear scan, truncating interpolation
  function automatic reading_t predict_reading(input sample_t s);
    reading_t         r;
    logic [VAL_W-1:0] v;
    int               idx;
    int               lo_c;
    int               hi_c;
    int               frac;
    int               t;
    v      = FULL_SCALE - {1'b0, s.adc};
    r.temp = OOR_CODE;
    r.oor  = 1'b1;
    if (v > CURVE[0] && v <= CURVE[USED_N-1]) begin
      idx = 1;
      while (CURVE[idx] < v) idx++;
      lo_c = int'(CURVE[idx-1]);
      hi_c = int'(CURVE[idx]);
      frac = (hi_c > lo_c) ? ((int'(v) - lo_c) * TENTHS_PER_STEP) / (hi_c - lo_c) : 0;
      t = (idx - INDEX_OFFSET) * TENTHS_PER_STEP + frac + int'(s.cal) - TRIM_TENTHS;
      r.temp = t[TEMP_W-1:0];
      r.oor  = 1'b0;
    end
    return r;
  endfunction

  task automatic add_sample(input int adc, input int cal);
    sample_t s;
    s.adc = adc[SAMPLE_W-1:0];
    s.cal = cal[CAL_W-1:0];
    pending_samples.push_back(s);
  endtask

  task automatic add_random_sample();
    int pick;
    int adc;
    pick = $urandom_range(99, 0);
    if (pick < 75) begin
      adc = $urandom_range(3902, 123);
    end else if (pick < 88) begin
      // land exactly on a curve entry
      adc = 4096 - int'(CURVE[$urandom_range(USED_N-1, 1)]);
    end else begin
      adc = $urandom_range(4095, 0);
    end
    add_sample(adc, $urandom_range(2047, 0) - 1024);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || start || expected_readings.size() != 0);
  endtask

  // driver: one transfer per start with busy low
  always @(posedge clk) begin
    logic accepted;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      accepted = start && !busy;
      if (accepted) expected_readings.push_back(predict_reading(sample_on_bus));
      if (!start || accepted) begin
        if (pending_samples.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          sample_on_bus = pending_samples.pop_front();
          start                 <= 1'b1;
          in_adc_sample         <= sample_on_bus.adc;
          in_calibration_tenths <= sample_on_bus.cal;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected result: temperature_tenths %0d out_of_range %0b",
               out_temperature_tenths, out_out_of_range);
        failures++;
      end else begin
        want = expected_readings.pop_front();
        if (out_temperature_tenths !== want.temp) begin
          $error("temperature_tenths: expected %0d, got %0d", want.temp,
                 out_temperature_tenths);
          failures++;
        end
        if (out_out_of_range !== want.oor) begin
          $error("out_of_range: expected %0b, got %0b", want.oor, out_out_of_range);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_ntc_adc_to_temperature_top NOT OK");
      $finish;
    end
  end

  initial begin
    int idle_phases[4];
    idle_phases = '{0, 46, 0, 20};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // extremes of both fields, table edges and exact hits
    add_sample(0, 0);
    add_sample(4095, 0);
    add_sample(3903, 500);
    add_sample(3902, 0);
    add_sample(3902, -1024);
    add_sample(3892, 0);
    add_sample(124, 0);
    add_sample(123, 0);
    add_sample(123, 1023);
    add_sample(122, -7);
    add_sample(2048, 0);
    add_sample(2048, -1000);
    add_sample(2048, 1000);
    add_sample(3072, 1);
    add_sample(1000, -1);
    add_sample(4096 - 3972, 0);
    add_sample(4096 - 2049, 333);
    add_sample(1365, -682);
    add_sample(2730, 682);
    add_sample(4095, -1024);
    wait_drained();

    foreach (idle_phases[p]) begin
      sender_idle_pct = idle_phases[p];
      repeat (ITEMS_PER_PHASE) add_random_sample();
      // hold off new samples until every reading is back
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_readings.size() != 0) begin
      $error("%0d readings never arrived", expected_readings.size());
      failures++;
    end
    if (failures == 0) begin
      $display("tb_ntc_adc_to_temperature_top OK");
    end else begin
      $display("tb_ntc_adc_to_temperature_top NOT OK");
    end
    $finish;
  end

endmodule

### files.f
sv/ntc_pkg.sv
sv/ntc_curve_rom.sv
sv/ntc_serial_div.sv
sv/ntc_adc_to_temperature_top.sv
test/tb_ntc_adc_to_temperature_top.sv
